// ===== hw/rtl/utf8_stream_validator_macros.svh =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTH
// Checked with reset as the disable condition.
`define U8SV_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define U8SV_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8SV_ASSERT(name, clk, rst, prop, msg)
`define U8SV_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/u8sv_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator package
// Byte class limits, code point limits and the character word type.
// ---------------------------------------------------------------------------
package u8sv_pkg;

   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] CONT_MIN  = 8'h80;
   localparam logic [7:0] CONT_MAX  = 8'hBF;
   localparam logic [7:0] LEAD2_MIN = 8'hC2;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;
   localparam logic [7:0] LEAD4_MAX = 8'hF4;

   localparam logic [20:0] CP_MIN2   = 21'h00080;
   localparam logic [20:0] CP_MIN3   = 21'h00800;
   localparam logic [20:0] CP_MIN4   = 21'h10000;
   localparam logic [20:0] CP_MAX    = 21'h10FFFF;
   localparam logic [20:0] SURR_LO   = 21'h0D800;
   localparam logic [20:0] SURR_HI   = 21'h0DFFF;

   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   // One finished character (or one error word) handed from front to back.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;   // index of the final byte
      logic [20:0]     scalar_value;
      logic            error;
   } char_type;

   // Head of the character queue as seen by the back end.
   typedef struct packed {
      logic     valid;
      char_type chr;
   } q_head_type;

endpackage

// ===== hw/rtl/u8sv_stream_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator channels
// Valid/ready byte input channel and decoded result channel.
// ---------------------------------------------------------------------------
interface u8sv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8sv_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_of_char;
   logic [20:0] scalar_value;
   logic        error;

   modport source (output valid, output out_byte, output last_of_char,
                   output scalar_value, output error, input ready);
   modport sink   (input valid, input out_byte, input last_of_char,
                   input scalar_value, input error, output ready);
endinterface

// ===== hw/rtl/utf8_stream_validator.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a byte stream as UTF-8 and releases each valid character with its
// decoded code point; any fault turns the stream into sticky error words.
// ---------------------------------------------------------------------------
//   channel    dir   handshake      word contents
//   req_chan   in    valid/ready    in_byte
//   rsp_chan   out   valid/ready    out_byte, last_of_char, scalar_value, error
//
// One byte is taken per cycle while the queue has room; a character's words
// leave one per cycle while rsp_chan is ready. The queue holds each finished
// character, then the output register loads its words. The back end's single
// output port gives one word per byte of a valid character, one per fault.
// req_chan.ready drops only when the character queue (QUEUE_DEPTH) is full.
// Synchronous reset clears the stream state and empties the queue.
// ---------------------------------------------------------------------------
module utf8_stream_validator
   import u8sv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   u8sv_req_if.sink   req_chan,
   u8sv_rsp_if.source rsp_chan
);

   logic       q_full;
   logic       q_push;
   char_type   q_push_chr;
   logic       q_pop;
   q_head_type q_head;

   // classify bytes and hold open characters
   u8sv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_full   (q_full),
      .push     (q_push),
      .push_chr (q_push_chr)
   );

   // decouple the byte side from the word side
   u8sv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_chr (q_push_chr),
      .pop      (q_pop),
      .full     (q_full),
      .head     (q_head)
   );

   // advance through each character's bytes, one word per cycle while rsp is ready
   u8sv_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .pop   (q_pop),
      .rsp   (rsp_chan)
   );

endmodule

// ===== hw/rtl/u8sv_front.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator front end
// Accepts bytes, holds open characters and checks each one when it completes.
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_macros.svh"

module u8sv_front
   import u8sv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8sv_req_if.sink    req,
   input  logic        q_full,
   output logic        push,
   output char_type    push_chr
);

   logic            stream_ok_ff, stream_ok_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [2:0]      seq_len_ff, seq_len_in;
   logic [20:0]     partial_ff, partial_in;
   logic [7:0]      held_ff [3];
   logic [7:0]      held_in [3];

   logic            accept;
   logic            produce;
   logic            fail;
   logic [7:0]      b;
   logic [20:0]     gathered;
   logic [20:0]     minimum;
   logic            cont_ok;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign gathered  = {partial_ff[14:0], b[5:0]};
   assign push      = accept && produce;

   always_comb begin
      stream_ok_in  = stream_ok_ff;
      held_count_in = held_count_ff;
      seq_len_in    = seq_len_ff;
      partial_in    = partial_ff;
      held_in       = held_ff;
      produce       = 1'b0;
      fail          = 1'b0;
      push_chr      = '0;
      minimum       = CP_MIN4;
      cont_ok       = 1'b1;

      if (!stream_ok_ff) begin
         fail = 1'b1;
      end else if (held_count_ff == 2'd0) begin
         if (b <= ASCII_MAX) begin
            produce               = 1'b1;
            push_chr.bytes[0]     = b;
            push_chr.scalar_value = {13'd0, b};
         end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            seq_len_in = SEQ_LEN2;
            partial_in = {16'd0, b[4:0]};
         end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            seq_len_in = SEQ_LEN3;
            partial_in = {17'd0, b[3:0]};
         end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            seq_len_in = SEQ_LEN4;
            partial_in = {18'd0, b[2:0]};
         end else begin
            fail = 1'b1;
         end
         if (!fail && b > ASCII_MAX) begin
            held_in[0]    = b;
            held_count_in = 2'd1;
         end
      end else if (({1'b0, held_count_ff} + 3'd1) < seq_len_ff) begin
         // middle byte: gather bits, check later
         partial_in             = gathered;
         held_in[held_count_ff] = b;
         held_count_in          = held_count_ff + 2'd1;
      end else begin
         // final byte: check the whole character
         unique case (seq_len_ff)
            SEQ_LEN2: minimum = CP_MIN2;
            SEQ_LEN3: minimum = CP_MIN3;
            default:  minimum = CP_MIN4;
         endcase
         cont_ok = (b >= CONT_MIN && b <= CONT_MAX);
         if (held_count_ff >= 2'd2 && !(held_ff[1] >= CONT_MIN && held_ff[1] <= CONT_MAX))
            cont_ok = 1'b0;
         if (held_count_ff == 2'd3 && !(held_ff[2] >= CONT_MIN && held_ff[2] <= CONT_MAX))
            cont_ok = 1'b0;
         if (!cont_ok || gathered < minimum || gathered > CP_MAX ||
             (gathered >= SURR_LO && gathered <= SURR_HI)) begin
            fail = 1'b1;
         end else begin
            produce               = 1'b1;
            push_chr.bytes[0]     = held_ff[0];
            push_chr.bytes[1]     = (held_count_ff == 2'd1) ? b : held_ff[1];
            push_chr.bytes[2]     = (held_count_ff == 2'd2) ? b : held_ff[2];
            push_chr.bytes[3]     = b;
            push_chr.last_idx     = held_count_ff;
            push_chr.scalar_value = gathered;
            held_count_in         = 2'd0;
            seq_len_in            = SEQ_NONE;
            partial_in            = '0;
         end
      end

      if (fail) begin
         produce           = 1'b1;
         push_chr          = '0;
         push_chr.error    = 1'b1;
         stream_ok_in      = 1'b0;
         held_count_in     = 2'd0;
         seq_len_in        = SEQ_NONE;
         partial_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ok_ff  <= 1'b1;
         held_count_ff <= 2'd0;
         seq_len_ff    <= SEQ_NONE;
         partial_ff    <= '0;
      end else if (accept) begin
         stream_ok_ff  <= stream_ok_in;
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
         partial_ff    <= partial_in;
      end
   end

   // held bytes are payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   `U8SV_ASSERT(a_err_sticky, clock, reset, !stream_ok_ff |=> !stream_ok_ff, "error cleared")
   `U8SV_ASSERT(a_held_below_len, clock, reset, (held_count_ff != 2'd0) |-> (seq_len_ff > 3'(held_count_ff)), "held count reached length")

endmodule

// ===== hw/rtl/u8sv_queue.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator character queue
// Short FIFO of finished characters between front and back end.
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_macros.svh"

module u8sv_queue
   import u8sv_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  char_type    push_chr,
   input  logic        pop,
   output logic        full,
   output q_head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   char_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.chr   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_chr;
      end
   end

   `U8SV_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `U8SV_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)), "queue count did not advance")

endmodule

// ===== hw/rtl/u8sv_back.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator back end
// Serializes each queued character into result words through an output register.
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_macros.svh"

module u8sv_back
   import u8sv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  q_head_type  head,
   output logic        pop,
   u8sv_rsp_if.source  rsp
);

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic [20:0] out_cp_ff;
   logic        out_error_ff;
   logic [1:0]  idx_ff;

   logic        load;
   logic        at_last;

   assign load    = !out_valid_ff || rsp.ready;
   assign at_last = (idx_ff == head.chr.last_idx);
   assign pop     = load && head.valid && at_last;

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_byte     = out_byte_ff;
   assign rsp.last_of_char = out_last_ff;
   assign rsp.scalar_value = out_cp_ff;
   assign rsp.error        = out_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (load) begin
         out_valid_ff <= head.valid;
         if (head.valid) begin
            idx_ff <= at_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head.valid) begin
         out_byte_ff  <= head.chr.bytes[idx_ff];
         out_last_ff  <= at_last;
         out_cp_ff    <= head.chr.scalar_value;
         out_error_ff <= head.chr.error;
      end
   end

   `U8SV_ASSERT(a_err_word, clock, reset, (out_valid_ff && out_error_ff) |-> (out_last_ff && out_byte_ff == 8'd0 && out_cp_ff == 21'd0), "malformed error word")

endmodule

// ===== bench/u8sv_char_checker.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator character checker
// Watches both channels, decodes every accepted input word on its own copy
// of the stream state and compares each result word with the oldest due one.
// ---------------------------------------------------------------------------
module u8sv_char_checker
   import u8sv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   u8sv_req_if  req_mon,
   u8sv_rsp_if  rsp_mon,
   output int   fail_count,
   output int   words_due
);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last_of_char;
      logic [20:0] scalar_value;
      logic        error;
   } char_word_type;

   char_word_type due_words[$];

   logic        stream_ok;
   logic [7:0]  held[3];
   logic [1:0]  held_cnt;
   logic [2:0]  char_len;
   logic [20:0] gathered;
   int          fails;

   function automatic void drop_char();
      held_cnt = 2'd0;
      char_len = SEQ_NONE;
      gathered = '0;
   endfunction

   function automatic void push_fault();
      stream_ok = 1'b0;
      drop_char();
      due_words.push_back('{8'h00, 1'b1, 21'h0, 1'b1});
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      int          i;
      logic        ok;
      logic [20:0] floor_cp;
      if (!stream_ok) begin
         push_fault();
         return;
      end
      if (held_cnt == 2'd0) begin
         if (b <= ASCII_MAX) begin
            due_words.push_back('{b, 1'b1, {13'h0, b}, 1'b0});
            return;
         end
         if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            char_len = SEQ_LEN2;
            gathered = {16'h0, b[4:0]};
         end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            char_len = SEQ_LEN3;
            gathered = {17'h0, b[3:0]};
         end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            char_len = SEQ_LEN4;
            gathered = {18'h0, b[2:0]};
         end else begin
            push_fault();
            return;
         end
         held[0]  = b;
         held_cnt = 2'd1;
         return;
      end
      // continuation slot: gather bits now, judge the bytes at completion
      gathered = {gathered[14:0], b[5:0]};
      if ((held_cnt + 3'd1 < char_len) && (held_cnt < 2'd3)) begin
         held[held_cnt] = b;
         held_cnt       = held_cnt + 2'd1;
         return;
      end
      ok = (b >= CONT_MIN && b <= CONT_MAX);
      for (i = 1; i < held_cnt; i++)
         if (!(held[i] >= CONT_MIN && held[i] <= CONT_MAX))
            ok = 1'b0;
      case (char_len)
         SEQ_LEN2: floor_cp = CP_MIN2;
         SEQ_LEN3: floor_cp = CP_MIN3;
         default:  floor_cp = CP_MIN4;
      endcase
      if (gathered < floor_cp || gathered > CP_MAX ||
          (gathered >= SURR_LO && gathered <= SURR_HI))
         ok = 1'b0;
      if (!ok) begin
         push_fault();
         return;
      end
      for (i = 0; i < held_cnt; i++)
         due_words.push_back('{held[i], 1'b0, gathered, 1'b0});
      due_words.push_back('{b, 1'b1, gathered, 1'b0});
      drop_char();
   endfunction

   always @(posedge clock) begin
      char_word_type want;
      if (reset) begin
         stream_ok = 1'b1;
         drop_char();
         due_words.delete();
         fails = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.in_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_words.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: word with nothing due: byte %h last %b cp %h err %b",
                           $time, rsp_mon.out_byte, rsp_mon.last_of_char,
                           rsp_mon.scalar_value, rsp_mon.error);
            end else begin
               want = due_words.pop_front();
               if (want.out_byte !== rsp_mon.out_byte ||
                   want.last_of_char !== rsp_mon.last_of_char ||
                   want.scalar_value !== rsp_mon.scalar_value ||
                   want.error !== rsp_mon.error) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: word mismatch: expected byte %h last %b cp %h err %b",
                              $time, want.out_byte, want.last_of_char,
                              want.scalar_value, want.error);
                     $display("%0t: word mismatch: got      byte %h last %b cp %h err %b",
                              $time, rsp_mon.out_byte, rsp_mon.last_of_char,
                              rsp_mon.scalar_value, rsp_mon.error);
                  end
               end
            end
         end
      end
      fail_count <= fails;
      words_due  <= due_words.size();
   end

endmodule

// ===== bench/tb_utf8_stream_validator.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream validator testbench
// Feeds boundary characters, then random well-formed text with one fault of
// a randomly chosen kind and trailing noise; the character checker predicts
// and compares every result word while both sides idle at random.
// ---------------------------------------------------------------------------
module tb_utf8_stream_validator
   import u8sv_pkg::*;
();

   typedef enum int {
      FAULT_BAD_LEAD,
      FAULT_BAD_CONT,
      FAULT_OVERLONG,
      FAULT_SURROGATE,
      FAULT_TOO_BIG
   } fault_kind_type;

   logic       clock;
   logic       reset;
   logic       steady;      // high: neither side idles
   int         fail_count;
   int         words_due;
   logic [7:0] tx_bytes[$];  // bytes waiting to be sent

   u8sv_req_if req_chan();
   u8sv_rsp_if rsp_chan();

   utf8_stream_validator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   u8sv_char_checker char_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("[utf8_stream_validator] ERROR");
      $finish;
   end

   // Result side: hold ready low with a chance of 22 in a hundred, never while steady.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= steady || ($urandom_range(99) >= 22);
      end
   end

   // Append the UTF-8 form of cp in len bytes; the lead takes what is left
   // of cp above the continuation bits, so overlong and too-big forms work.
   function automatic void queue_char(input logic [20:0] cp, input int len);
      case (len)
         1: tx_bytes.push_back(cp[7:0]);
         2: begin
            tx_bytes.push_back({3'b110, cp[10:6]});
            tx_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            tx_bytes.push_back({4'b1110, cp[15:12]});
            tx_bytes.push_back({2'b10, cp[11:6]});
            tx_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            tx_bytes.push_back({5'b11110, cp[20:18]});
            tx_bytes.push_back({2'b10, cp[17:12]});
            tx_bytes.push_back({2'b10, cp[11:6]});
            tx_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Pick a legal scalar value that needs exactly len bytes.
   function automatic logic [20:0] random_scalar(input int len);
      logic [20:0] cp;
      case (len)
         1: cp = 21'($urandom_range(0, 32'h7F));
         2: cp = 21'($urandom_range(32'h80, 32'h7FF));
         3: begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            // step out of the surrogate block
            if (cp >= SURR_LO && cp <= SURR_HI)
               cp = cp - 21'h800;
         end
         default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
      endcase
      return cp;
   endfunction

   // Append one broken character of the given kind.
   function automatic void queue_fault(input fault_kind_type kind);
      int len;
      int pos;
      case (kind)
         FAULT_BAD_LEAD:
            tx_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                 : 8'($urandom_range(8'hF5, 8'hFF)));
         FAULT_BAD_CONT: begin
            // spoil one continuation slot with ASCII or a lead-range byte
            len = $urandom_range(2, 4);
            queue_char(random_scalar(len), len);
            pos = tx_bytes.size() - len + $urandom_range(1, len - 1);
            tx_bytes[pos] = $urandom_range(1) ? 8'($urandom_range(0, 8'h7F))
                                              : 8'($urandom_range(8'hC0, 8'hFF));
         end
         FAULT_OVERLONG:
            if ($urandom_range(1))
               queue_char(21'($urandom_range(0, 32'h7FF)), 3);
            else
               queue_char(21'($urandom_range(0, 32'hFFFF)), 4);
         FAULT_SURROGATE:
            queue_char(21'($urandom_range(SURR_LO, SURR_HI)), 3);
         default:
            queue_char(21'($urandom_range(32'h110000, 32'h13FFFF)), 4);
      endcase
   endfunction

   // Offer one word; idle first at random, hold it until it is taken.
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 22) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_queued();
      while (tx_bytes.size() != 0)
         send_byte(tx_bytes.pop_front());
   endtask

   // Drop valid and hold until every predicted word has come out.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (words_due != 0)
         @(negedge clock);
   endtask

   initial begin
      int k;
      int len;
      reset            = 1'b1;
      steady           = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Boundaries of every length and both edges of the surrogate gap.
      queue_char(21'h0, 1);
      queue_char(21'h7F, 1);
      queue_char(CP_MIN2, 2);
      queue_char(21'h7FF, 2);
      queue_char(CP_MIN3, 3);
      queue_char(SURR_LO - 21'h1, 3);
      queue_char(SURR_HI + 21'h1, 3);
      queue_char(21'hFFFF, 3);
      queue_char(CP_MIN4, 4);
      queue_char(CP_MAX, 4);
      send_queued();

      // Let the back end run dry once before the random text.
      drain();

      // Random well-formed text; run a stretch with no idling mid-way.
      for (k = 0; k < 50; k++) begin
         steady = (k >= 20 && k < 36);
         len    = $urandom_range(1, 4);
         queue_char(random_scalar(len), len);
         send_queued();
      end
      steady = 1'b0;

      // One fault turns the stream sticky; advance with raw noise after it.
      queue_fault(fault_kind_type'($urandom_range(FAULT_BAD_LEAD, FAULT_TOO_BIG)));
      for (k = 0; k < 20; k++)
         tx_bytes.push_back(8'($urandom_range(255)));
      send_queued();

      drain();
      // Leave room for any stray word to show up.
      repeat (16) @(negedge clock);
      if (fail_count == 0)
         $display("[utf8_stream_validator] OK");
      else
         $display("[utf8_stream_validator] ERROR");
      $finish;
   end

endmodule
